FILE: rtl/core/hds_pkg.sv
// ----------------------------------------------------------------------------
// hds_pkg
// Shared types, constants and tables of the hemisphere direction sampler.
// ----------------------------------------------------------------------------
package hds_pkg;

  localparam int unsigned LEN_BITS     = 24;
  localparam int unsigned SIN_BITS     = 17;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned DIV_BITS     = 17;
  localparam int unsigned IN_W         = 80;
  localparam int unsigned OUT_W        = 48;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [32:0]        TWO_PI_Q30  = 33'd6746518852;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic signed [15:0] normal_z;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_x;
    logic [15:0]        rand_b;
    logic [15:0]        rand_a;
  } in_t;

  typedef struct packed {
    logic signed [15:0] dir_z;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_x;
  } out_t;

  typedef struct packed {
    logic [15:0]        u1;
    logic [1:0]         quad;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               sel;
    logic [31:0]        len2;
    logic [26:0]        len_rem;
    logic [23:0]        len_root;
    logic [33:0]        sin_rad;
    logic [19:0]        sin_rem;
    logic [16:0]        sin_root;
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [33:0] cz;
    logic [15:0]        mag_a;
    logic [15:0]        mag_b;
    logic               neg_a;
    logic               neg_b;
  } step_t;

  typedef struct packed {
    logic [15:0]        u1;
    logic [1:0]         quad;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               sel;
    logic [23:0]        len;
    logic               zero;
    logic [39:0]        ra;
    logic [39:0]        rb;
    logic [16:0]        qa;
    logic [16:0]        qb;
    logic               neg_a;
    logic               neg_b;
    logic [16:0]        sin_t;
    logic signed [19:0] px;
    logic signed [19:0] py;
    logic signed [19:0] cs;
    logic signed [19:0] sn;
    logic signed [37:0] lxp;
    logic signed [37:0] lyp;
  } div_t;

  function automatic logic signed [33:0] atan_q30(input logic [3:0] i);
    logic signed [33:0] r;
    case (i)
      4'd0:    r = 34'sh03243F6A8;
      4'd1:    r = 34'sh01DAC6705;
      4'd2:    r = 34'sh00FADBAFC;
      4'd3:    r = 34'sh007F56EA6;
      4'd4:    r = 34'sh003FEAB76;
      4'd5:    r = 34'sh001FFD55B;
      4'd6:    r = 34'sh000FFFAAA;
      4'd7:    r = 34'sh0007FFF55;
      4'd8:    r = 34'sh0003FFFEA;
      4'd9:    r = 34'sh0001FFFFD;
      4'd10:   r = 34'sh0000FFFFF;
      4'd11:   r = 34'sh00007FFFF;
      4'd12:   r = 34'sh00003FFFF;
      4'd13:   r = 34'sh00001FFFF;
      4'd14:   r = 34'sh00000FFFF;
      default: r = 34'sh000007FFF;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/hemisphere_direction_sampler_unit.sv
// ----------------------------------------------------------------------------
// hemisphere_direction_sampler_unit
// Uniform hemisphere direction sampler around a surface normal, fixed point.
//
// Slave stream: one transfer carries u1, u2 (Q0.16) and the normal (Q1.15).
// Master stream: one transfer per input carries the direction (Q1.15).
// Throughput: one transfer per cycle while the receiver does not stall. The
// pipeline is built of the 24 digit stages of the tangent length root and the
// 17 quotient stages of the tangent division, with 3 front and 6 back stages
// around them.
// Reset clears every valid bit and the output skid valid flag; data is not
// cleared. When the receiver stalls, the finished item is parked in the skid
// register, tready drops in the next cycle and the whole pipeline holds until
// the parked item is taken; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module hemisphere_direction_sampler_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [hds_pkg::IN_W-1:0]  s_axis_tdata_i,   // rand_a, rand_b, normal_x, normal_y, normal_z
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [hds_pkg::OUT_W-1:0] m_axis_tdata_o    // dir_x, dir_y, dir_z
);

  localparam int unsigned NS = hds_pkg::LEN_BITS;
  localparam int unsigned ND = hds_pkg::DIV_BITS;

  logic            en;
  logic            step_vld [NS+1];
  hds_pkg::step_t  step_d   [NS+1];
  logic            div_vld  [ND+1];
  hds_pkg::div_t   div_d    [ND+1];
  logic            p_vld;
  hds_pkg::out_t   p_data;
  logic            skid_vld_q;
  hds_pkg::out_t   skid_q;
  hds_pkg::step_t  sl;

  assign en              = !skid_vld_q;
  assign s_axis_tready_o = en;

  hds_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid_i),
    .data_i (hds_pkg::in_t'(s_axis_tdata_i)),
    .vld_o  (step_vld[0]),
    .data_o (step_d[0])
  );

  for (genvar k = 0; k < NS; k++) begin : g_step
    hds_step #(.IDX(k)) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (step_vld[k]),
      .data_i (step_d[k]),
      .vld_o  (step_vld[k+1]),
      .data_o (step_d[k+1])
    );
  end

  always_comb begin
    sl          = step_d[NS];
    div_vld[0]  = step_vld[NS];
    div_d[0]    = '0;
    div_d[0].u1    = sl.u1;
    div_d[0].quad  = sl.quad;
    div_d[0].nx    = sl.nx;
    div_d[0].ny    = sl.ny;
    div_d[0].nz    = sl.nz;
    div_d[0].sel   = sl.sel;
    div_d[0].len   = sl.len_root;
    div_d[0].ra    = {sl.mag_a, 24'b0};
    div_d[0].rb    = {sl.mag_b, 24'b0};
    div_d[0].neg_a = sl.neg_a;
    div_d[0].neg_b = sl.neg_b;
    div_d[0].sin_t = sl.sin_root;
    div_d[0].px    = sl.cx[33:14];
    div_d[0].py    = sl.cy[33:14];
  end

  for (genvar k = 0; k < ND; k++) begin : g_div
    hds_div #(.IDX(ND - 1 - k)) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (div_vld[k]),
      .data_i (div_d[k]),
      .vld_o  (div_vld[k+1]),
      .data_o (div_d[k+1])
    );
  end

  hds_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (div_vld[ND]),
    .data_i (div_d[ND]),
    .vld_o  (p_vld),
    .data_o (p_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (en) begin
      skid_vld_q <= p_vld && !m_axis_tready_i;
    end else if (m_axis_tready_i) begin
      skid_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && p_vld && !m_axis_tready_i) begin
      skid_q <= p_data;
    end
  end

  assign m_axis_tvalid_o = skid_vld_q || p_vld;
  assign m_axis_tdata_o  = skid_vld_q ? skid_q : p_data;

endmodule

FILE: rtl/core/hds_front.sv
// ----------------------------------------------------------------------------
// hds_front
// Input register, squares and azimuth scaling, tangent selection setup.
// ----------------------------------------------------------------------------
module hds_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  hds_pkg::in_t     data_i,
  output logic             vld_o,
  output hds_pkg::step_t   data_o
);

  logic                v0_q, v1_q, v2_q;
  hds_pkg::in_t        in_q;
  logic [31:0]         nx2_q, ny2_q, nz2_q, u1sq_q;
  logic [30:0]         z0_q;
  hds_pkg::in_t        in1_q;
  hds_pkg::step_t      out_q;

  logic signed [31:0]  sx, sy, sz;
  logic [31:0]         su;
  logic [46:0]         zp;
  logic                sel;
  logic signed [15:0]  m;
  hds_pkg::step_t      out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= vld_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_comb begin
    sx = in_q.normal_x * in_q.normal_x;
    sy = in_q.normal_y * in_q.normal_y;
    sz = in_q.normal_z * in_q.normal_z;
    su = 32'(in_q.rand_a) * 32'(in_q.rand_a);
    zp = 47'(in_q.rand_b[13:0]) * 47'(hds_pkg::TWO_PI_Q30);
  end

  always_comb begin
    sel = nx2_q > ny2_q;
    m   = sel ? in1_q.normal_x : in1_q.normal_y;
    out_d          = '0;
    out_d.u1       = in1_q.rand_a;
    out_d.quad     = in1_q.rand_b[15:14];
    out_d.nx       = in1_q.normal_x;
    out_d.ny       = in1_q.normal_y;
    out_d.nz       = in1_q.normal_z;
    out_d.sel      = sel;
    out_d.len2     = (sel ? nx2_q : ny2_q) + nz2_q;
    out_d.sin_rad  = 34'h1_0000_0000 - 34'(u1sq_q);
    out_d.cx       = hds_pkg::CORDIC_GAIN;
    out_d.cy       = '0;
    out_d.cz       = $signed(34'(z0_q));
    out_d.neg_a    = in1_q.normal_z[15];
    out_d.mag_a    = in1_q.normal_z[15] ? 16'(-in1_q.normal_z) : in1_q.normal_z;
    out_d.neg_b    = !m[15] && (m != 16'sd0);
    out_d.mag_b    = m[15] ? 16'(-m) : m;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      in_q   <= data_i;
      nx2_q  <= sx;
      ny2_q  <= sy;
      nz2_q  <= sz;
      u1sq_q <= su;
      z0_q   <= zp[46:16];
      in1_q  <= in_q;
      out_q  <= out_d;
    end
  end

  assign vld_o  = v2_q;
  assign data_o = out_q;

endmodule

FILE: rtl/core/hds_step.sv
// ----------------------------------------------------------------------------
// hds_step
// One stage: length root digit; early ones add a sin digit and a CORDIC step.
// ----------------------------------------------------------------------------
module hds_step #(
  parameter int unsigned IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  hds_pkg::step_t   data_i,
  output logic             vld_o,
  output hds_pkg::step_t   data_o
);

  localparam int unsigned LPOS = 47 - 2 * IDX;

  logic           vld_q;
  hds_pkg::step_t q;
  hds_pkg::step_t d;
  logic [47:0]    lv;
  logic [26:0]    lrem, ltrial;
  logic [19:0]    sin_rem_n;
  logic [16:0]    sin_root_n;
  logic signed [33:0] cx_n, cy_n, cz_n;

  always_comb begin
    lv     = {data_i.len2, 16'b0};
    lrem   = {data_i.len_rem[24:0], lv[LPOS -: 2]};
    ltrial = {1'b0, data_i.len_root, 2'b01};
  end

  if (IDX < hds_pkg::SIN_BITS) begin : g_sin
    localparam int unsigned SPOS = 33 - 2 * IDX;
    logic [19:0] srem, strial;
    always_comb begin
      srem   = {data_i.sin_rem[17:0], data_i.sin_rad[SPOS -: 2]};
      strial = {1'b0, data_i.sin_root, 2'b01};
      if (srem >= strial) begin
        sin_rem_n  = srem - strial;
        sin_root_n = {data_i.sin_root[15:0], 1'b1};
      end else begin
        sin_rem_n  = srem;
        sin_root_n = {data_i.sin_root[15:0], 1'b0};
      end
    end
  end else begin : g_sin_hold
    assign sin_rem_n  = data_i.sin_rem;
    assign sin_root_n = data_i.sin_root;
  end

  if (IDX < hds_pkg::CORDIC_STEPS) begin : g_rot
    logic signed [33:0] dx, dy, at;
    always_comb begin
      dx = data_i.cy >>> IDX;
      dy = data_i.cx >>> IDX;
      at = hds_pkg::atan_q30(4'(IDX));
      if (!data_i.cz[33]) begin
        cx_n = data_i.cx - dx;
        cy_n = data_i.cy + dy;
        cz_n = data_i.cz - at;
      end else begin
        cx_n = data_i.cx + dx;
        cy_n = data_i.cy - dy;
        cz_n = data_i.cz + at;
      end
    end
  end else begin : g_rot_hold
    assign cx_n = data_i.cx;
    assign cy_n = data_i.cy;
    assign cz_n = data_i.cz;
  end

  always_comb begin
    d = data_i;
    if (lrem >= ltrial) begin
      d.len_rem  = lrem - ltrial;
      d.len_root = {data_i.len_root[22:0], 1'b1};
    end else begin
      d.len_rem  = lrem;
      d.len_root = {data_i.len_root[22:0], 1'b0};
    end
    d.sin_rem  = sin_rem_n;
    d.sin_root = sin_root_n;
    d.cx       = cx_n;
    d.cy       = cy_n;
    d.cz       = cz_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q <= d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = q;

endmodule

FILE: rtl/core/hds_div.sv
// ----------------------------------------------------------------------------
// hds_div
// One quotient bit of both tangent divisions; early stages also place the
// azimuth in its quadrant and scale it by sin theta.
// ----------------------------------------------------------------------------
module hds_div #(
  parameter int unsigned IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  hds_pkg::div_t   data_i,
  output logic            vld_o,
  output hds_pkg::div_t   data_o
);

  logic          vld_q;
  hds_pkg::div_t q;
  hds_pkg::div_t d;
  logic [39:0]   dv;
  logic signed [19:0] cs_n, sn_n;
  logic               zero_n;
  logic signed [37:0] lxp_n, lyp_n;

  if (IDX == hds_pkg::DIV_BITS - 1) begin : g_quad
    always_comb begin
      zero_n = (data_i.len == 24'd0);
      case (data_i.quad)
        hds_pkg::QUAD_0: begin
          cs_n = data_i.px;
          sn_n = data_i.py;
        end
        hds_pkg::QUAD_1: begin
          cs_n = -data_i.py;
          sn_n = data_i.px;
        end
        hds_pkg::QUAD_2: begin
          cs_n = -data_i.px;
          sn_n = -data_i.py;
        end
        default: begin
          cs_n = data_i.py;
          sn_n = -data_i.px;
        end
      endcase
    end
  end else begin : g_quad_hold
    assign zero_n = data_i.zero;
    assign cs_n   = data_i.cs;
    assign sn_n   = data_i.sn;
  end

  if (IDX == hds_pkg::DIV_BITS - 2) begin : g_scale
    always_comb begin
      lxp_n = $signed({1'b0, data_i.sin_t}) * data_i.cs;
      lyp_n = $signed({1'b0, data_i.sin_t}) * data_i.sn;
    end
  end else begin : g_scale_hold
    assign lxp_n = data_i.lxp;
    assign lyp_n = data_i.lyp;
  end

  always_comb begin
    dv     = 40'(data_i.len) << IDX;
    d      = data_i;
    d.zero = zero_n;
    d.cs   = cs_n;
    d.sn   = sn_n;
    d.lxp  = lxp_n;
    d.lyp  = lyp_n;
    if (data_i.ra >= dv) begin
      d.ra      = data_i.ra - dv;
      d.qa[IDX] = 1'b1;
    end
    if (data_i.rb >= dv) begin
      d.rb      = data_i.rb - dv;
      d.qb[IDX] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q <= d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = q;

endmodule

FILE: rtl/core/hds_back.sv
// ----------------------------------------------------------------------------
// hds_back
// Tangent signs, bitangent cross product, frame transform, rounding and
// saturation to Q1.15.
// ----------------------------------------------------------------------------
module hds_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  hds_pkg::div_t   data_i,
  output logic            vld_o,
  output hds_pkg::out_t   data_o
);

  logic [5:0] v_q;

  // stage b0
  logic signed [17:0] tx0_q, ty0_q, tz0_q;
  logic signed [19:0] lx0_q, ly0_q;
  logic signed [15:0] nx0_q, ny0_q, nz0_q;
  logic [15:0]        u10_q;
  logic               z0_q;
  logic signed [17:0] sa, sb;

  // stage b1
  logic signed [33:0] p_nytz_q, p_nzty_q, p_nztx_q, p_nxtz_q, p_nxty_q, p_nytx_q;
  logic signed [32:0] zx1_q, zy1_q, zz1_q;
  logic signed [17:0] tx1_q, ty1_q, tz1_q;
  logic signed [19:0] lx1_q, ly1_q;
  logic               z1_q;

  // stage b2
  logic signed [19:0] bx2_q, by2_q, bz2_q;
  logic signed [34:0] dfx, dfy, dfz;
  logic signed [32:0] zx2_q, zy2_q, zz2_q;
  logic signed [17:0] tx2_q, ty2_q, tz2_q;
  logic signed [19:0] lx2_q, ly2_q;
  logic               z2_q;

  // stage b3
  logic signed [37:0] ax3_q, ay3_q, az3_q;
  logic signed [39:0] bx3_q, by3_q, bz3_q;
  logic signed [32:0] zx3_q, zy3_q, zz3_q;
  logic               z3_q;

  // stage b4
  logic signed [41:0] sx4_q, sy4_q, sz4_q;
  logic               z4_q;

  // stage b5
  hds_pkg::out_t      out_q;

  function automatic logic signed [15:0] to_q15(input logic signed [41:0] s);
    logic signed [41:0] r;
    r = (s + 42'sd65536) >>> 17;
    if (r > 42'sd32767) begin
      return 16'sh7FFF;
    end else if (r < -42'sd32768) begin
      return 16'sh8000;
    end
    return r[15:0];
  endfunction

  always_comb begin
    sa = data_i.neg_a ? -$signed({1'b0, data_i.qa}) : $signed({1'b0, data_i.qa});
    sb = data_i.neg_b ? -$signed({1'b0, data_i.qb}) : $signed({1'b0, data_i.qb});
    dfx = 35'(p_nytz_q) - 35'(p_nzty_q);
    dfy = 35'(p_nztx_q) - 35'(p_nxtz_q);
    dfz = 35'(p_nxty_q) - 35'(p_nytx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tx0_q <= data_i.sel ? sa : 18'sd0;
      ty0_q <= data_i.sel ? 18'sd0 : sa;
      tz0_q <= sb;
      lx0_q <= data_i.lxp[35:16];
      ly0_q <= data_i.lyp[35:16];
      nx0_q <= data_i.nx;
      ny0_q <= data_i.ny;
      nz0_q <= data_i.nz;
      u10_q <= data_i.u1;
      z0_q  <= data_i.zero;

      p_nytz_q <= ny0_q * tz0_q;
      p_nzty_q <= nz0_q * ty0_q;
      p_nztx_q <= nz0_q * tx0_q;
      p_nxtz_q <= nx0_q * tz0_q;
      p_nxty_q <= nx0_q * ty0_q;
      p_nytx_q <= ny0_q * tx0_q;
      zx1_q    <= $signed({1'b0, u10_q}) * nx0_q;
      zy1_q    <= $signed({1'b0, u10_q}) * ny0_q;
      zz1_q    <= $signed({1'b0, u10_q}) * nz0_q;
      tx1_q    <= tx0_q;
      ty1_q    <= ty0_q;
      tz1_q    <= tz0_q;
      lx1_q    <= lx0_q;
      ly1_q    <= ly0_q;
      z1_q     <= z0_q;

      bx2_q <= dfx[34:15];
      by2_q <= dfy[34:15];
      bz2_q <= dfz[34:15];
      zx2_q <= zx1_q;
      zy2_q <= zy1_q;
      zz2_q <= zz1_q;
      tx2_q <= tx1_q;
      ty2_q <= ty1_q;
      tz2_q <= tz1_q;
      lx2_q <= lx1_q;
      ly2_q <= ly1_q;
      z2_q  <= z1_q;

      ax3_q <= lx2_q * tx2_q;
      ay3_q <= lx2_q * ty2_q;
      az3_q <= lx2_q * tz2_q;
      bx3_q <= ly2_q * bx2_q;
      by3_q <= ly2_q * by2_q;
      bz3_q <= ly2_q * bz2_q;
      zx3_q <= zx2_q;
      zy3_q <= zy2_q;
      zz3_q <= zz2_q;
      z3_q  <= z2_q;

      sx4_q <= 42'(ax3_q) + 42'(bx3_q) + (42'(zx3_q) <<< 1);
      sy4_q <= 42'(ay3_q) + 42'(by3_q) + (42'(zy3_q) <<< 1);
      sz4_q <= 42'(az3_q) + 42'(bz3_q) + (42'(zz3_q) <<< 1);
      z4_q  <= z3_q;

      out_q.dir_x <= z4_q ? 16'sd0 : to_q15(sx4_q);
      out_q.dir_y <= z4_q ? 16'sd0 : to_q15(sy4_q);
      out_q.dir_z <= z4_q ? 16'sd0 : to_q15(sz4_q);
    end
  end

  assign vld_o  = v_q[5];
  assign data_o = out_q;

endmodule

FILE: dv/tb_hemisphere_direction_sampler_unit.sv
// ----------------------------------------------------------------------------
// tb_hemisphere_direction_sampler_unit
// Streams sample requests into the hemisphere sampler and compares every
// output direction against a bit-exact fixed-point prediction, under random
// idling on both sides, a long output stall and a full drain pause.
// ----------------------------------------------------------------------------
module tb_hemisphere_direction_sampler_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES = 80;

  localparam longint ATAN_Q30 [16] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
    64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
  };
  localparam longint GAIN_Q30   = 64'd652032874;
  localparam longint TWO_PI_FIX = 64'd6746518852;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [79:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;

  hds_pkg::out_t dir_q[$];
  int unsigned err_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned quiet_cycles = 0;

  hemisphere_direction_sampler_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic longint scale_by_len(input longint c, input longint unsigned len);
    longint unsigned mag;
    longint q;
    mag = longint'(c < 0 ? -c : c) << 24;
    q = longint'(mag / len);
    return c < 0 ? -q : q;
  endfunction

  function automatic logic signed [15:0] round_sat_q15(input longint s);
    longint r;
    r = (s + 65536) >>> 17;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic hds_pkg::out_t predict_dir(input hds_pkg::in_t it);
    hds_pkg::out_t o;
    longint nx, ny, nz, tx, ty, tz, bx, by, bz;
    longint sin_t, cs, sn, lx, ly, lz, x, y, z, dx, dy;
    longint unsigned len2, len, a;
    logic [1:0] quad;
    logic use_x;
    nx = longint'($signed(it.normal_x));
    ny = longint'($signed(it.normal_y));
    nz = longint'($signed(it.normal_z));
    use_x = (nx * nx > ny * ny);
    len2 = use_x ? longint'(nx * nx + nz * nz) : longint'(ny * ny + nz * nz);
    len = int_sqrt(len2 << 16);
    o = '0;
    if (len == 0) return o;
    if (use_x) begin
      tx = scale_by_len(nz, len); ty = 0; tz = scale_by_len(-nx, len);
    end else begin
      tx = 0; ty = scale_by_len(nz, len); tz = scale_by_len(-ny, len);
    end
    bx = (ny * tz - nz * ty) >>> 15;
    by = (nz * tx - nx * tz) >>> 15;
    bz = (nx * ty - ny * tx) >>> 15;
    sin_t = longint'(int_sqrt((64'd1 << 32) - longint'(it.rand_a) * longint'(it.rand_a)));
    quad = it.rand_b[15:14];
    a = longint'(it.rand_b[13:0]);
    z = longint'((a * TWO_PI_FIX) >> 16);
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ATAN_Q30[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ATAN_Q30[i];
      end
    end
    x = x >>> 14;
    y = y >>> 14;
    case (quad)
      hds_pkg::QUAD_0: begin cs = x;  sn = y;  end
      hds_pkg::QUAD_1: begin cs = -y; sn = x;  end
      hds_pkg::QUAD_2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
    lx = (sin_t * cs) >>> 16;
    ly = (sin_t * sn) >>> 16;
    lz = longint'(it.rand_a);
    o.dir_x = round_sat_q15(lx * tx + ly * bx + 2 * lz * nx);
    o.dir_y = round_sat_q15(lx * ty + ly * by + 2 * lz * ny);
    o.dir_z = round_sat_q15(lx * tz + ly * bz + 2 * lz * nz);
    return o;
  endfunction

  function automatic hds_pkg::in_t make_item(input logic [15:0] ua, input logic [15:0] ub,
                                             input int nx, input int ny, input int nz);
    hds_pkg::in_t it;
    it.rand_a   = ua;
    it.rand_b   = ub;
    it.normal_x = nx[15:0];
    it.normal_y = ny[15:0];
    it.normal_z = nz[15:0];
    return it;
  endfunction

  function automatic hds_pkg::in_t random_item();
    hds_pkg::in_t it;
    int nx, ny, nz, rest;
    it.rand_a = 16'($urandom);
    it.rand_b = 16'($urandom);
    if ($urandom_range(99) < 75) begin
      nx = $urandom_range(46340) - 23170;
      ny = $urandom_range(46340) - 23170;
      rest = 32767 * 32767 - nx * nx - ny * ny;
      nz = int'(int_sqrt(longint'(rest)));
      case ($urandom_range(2))
        0: begin it.normal_x = nz[15:0]; it.normal_y = nx[15:0]; end
        1: begin it.normal_x = nx[15:0]; it.normal_y = nz[15:0]; end
        default: begin it.normal_x = nx[15:0]; it.normal_y = ny[15:0]; end
      endcase
      if ($urandom_range(1)) nz = -nz;
      it.normal_z = (it.normal_x == nz[15:0] || it.normal_y == nz[15:0]) ? ny[15:0] : nz[15:0];
    end else begin
      it.normal_x = 16'($urandom);
      it.normal_y = 16'($urandom);
      it.normal_z = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  task automatic send_item(input hds_pkg::in_t it);
    s_axis_tdata_i  <= it;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    dir_q.push_back(predict_dir(it));
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic wait_drained();
    while (dir_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      m_axis_tready_i <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    hds_pkg::out_t got;
    hds_pkg::out_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (dir_q.size() == 0) begin
        report_mismatch("unexpected output transfer", 1, 0);
      end else begin
        want = dir_q.pop_front();
        if (got.dir_x !== want.dir_x) report_mismatch("dir_x", got.dir_x, want.dir_x);
        if (got.dir_y !== want.dir_y) report_mismatch("dir_y", got.dir_y, want.dir_y);
        if (got.dir_z !== want.dir_z) report_mismatch("dir_z", got.dir_z, want.dir_z);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_item(make_item(16'h0000, 16'h0000, 0, 0, 32767));
    send_item(make_item(16'hFFFF, 16'hFFFF, 0, 0, 32767));
    send_item(make_item(16'h0000, 16'h3FFF, 32767, 0, 0));
    send_item(make_item(16'h8000, 16'h4000, 0, -32768, 0));
    send_item(make_item(16'h4000, 16'h8000, -32768, 0, 0));
    send_item(make_item(16'hC000, 16'hC000, 0, 32767, 0));
    send_item(make_item(16'h1234, 16'h5678, 0, 0, -32768));
    send_item(make_item(16'hFFFF, 16'h0001, 0, 0, 0));
    send_item(make_item(16'h0000, 16'hFFFF, 0, 0, 0));
    send_item(make_item(16'h9000, 16'h2000, 23170, 23170, 0));
    send_item(make_item(16'h7000, 16'hA000, -23170, 23170, 0));
    send_item(make_item(16'hFFFF, 16'h6000, -32768, -32768, -32768));
    send_item(make_item(16'h0001, 16'hE000, 32767, 32767, 32767));
    send_item(make_item(16'h0000, 16'h1000, -32768, 32767, -32768));
    send_item(make_item(16'h5555, 16'hAAAA, 1, 0, 0));
    send_item(make_item(16'hAAAA, 16'h5555, 0, -1, 0));
    send_item(make_item(16'h2000, 16'h7FFF, 18919, 18919, 18919));
    send_item(make_item(16'hE000, 16'hBFFF, -18919, 18919, -18919));
    send_item(make_item(16'h3000, 16'h0000, 0, 0, 1));
    send_item(make_item(16'hFFFE, 16'hFFFE, 32767, -32768, 0));
  endtask

  task automatic test_random(input int unsigned s_pct, input int unsigned r_pct,
                             input int unsigned n);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int unsigned i = 0; i < n; i++) send_item(random_item());
  endtask

  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 400;
    for (int unsigned i = 0; i < 150; i++) send_item(random_item());
  endtask

  task automatic test_drain_pause();
    s_axis_tvalid_i <= 1'b0;
    wait_drained();
    test_random(20, 20, 80);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(9, 84, 400);
    test_random(84, 9, 400);
    test_random(0, 0, 500);
    test_output_stall();
    test_drain_pause();
    s_axis_tvalid_i <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
